// File: rtl/ipa_pkg.sv
package ipa_pkg;

    // pool geometry
    localparam int POOL_DEPTH = 1024;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    // field widths
    localparam int ID_W   = 31;
    localparam int SIZE_W = 11;
    localparam int ACT_W  = 2;
    localparam int ST_W   = 3;

    // configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register indexes (paddr bit 2)
    localparam logic REG_BASE_ID   = 1'b0;
    localparam logic REG_POOL_SIZE = 1'b1;

    // action codes, the unused code behaves as query
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_DISABLED   = 3'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED  = 3'd2;
    localparam logic [ST_W-1:0] ST_RANGE      = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_IN_USE = 3'd4;

    // item held in the processing stage
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] idx;
        logic             in_range;
    } t_item;

    // result of one processing step
    typedef struct packed {
        logic             ok;
        logic [ID_W-1:0]  result_id;
        logic [ST_W-1:0]  status;
    } t_result;

endpackage

// File: rtl/ipa_ram.sv
module ipa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/id_pool_allocator_unit.sv
// ID pool allocator. Hands out IDs base_id .. base_id+pool_size-1 (pool_size capped at
// POOL_DEPTH): allocate returns the most recently released ID, else the lowest ID never
// issued; release takes back an ID that is in use; query tells whether an ID is in use.
// One item is accepted every cycle unless a result stall holds the stage; the accepting edge
// loads the processing stage, and the result register is loaded when the stage advances.
// That rate is set by the single processing stage that updates the stack count and fresh
// counter each cycle and forwards the stack top and the in-use bit into the next item's
// RAM reads. The in-use map needs no clearing pass: entries at or above the fresh counter
// read as free, so reset and any register write clear the pool at once. Any register
// write re-initializes the pool; write the registers only while no item is in flight.
module id_pool_allocator_unit
    import ipa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // input items
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [ID_W-1:0]   i_id,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_ok,
    output logic [ID_W-1:0]   o_result_id,
    output logic [ST_W-1:0]   o_status
);

    // configuration and pool state
    logic [ID_W-1:0]   r_base_id;
    logic [SIZE_W-1:0] r_pool_size;
    logic [CNT_W-1:0]  r_released_count, n_released_count;
    logic [CNT_W-1:0]  r_fresh_next, n_fresh_next;

    // processing stage
    logic              r_s1_valid;
    t_item             r_s1;
    t_item             s0_item;
    logic              r_use_hit, r_use_hit_val;
    logic              r_top_hit;
    logic [IDX_W-1:0]  r_top_hit_val;

    // result register
    logic              r_out_valid;
    t_result           r_out;
    t_result           res;

    logic              cfg_wr;
    logic              accept;
    logic              advance;
    logic [CNT_W-1:0]  usable;
    logic              disabled;
    logic [ID_W:0]     diff;

    // step decisions
    logic              cnt_dec, fresh_inc, push;
    logic              use_we, use_wdata;
    logic [IDX_W-1:0]  use_waddr;
    logic              in_use;
    logic [IDX_W-1:0]  top;
    logic [IDX_W-1:0]  use_rdata_idx_unused;
    logic              use_rdata;
    logic [IDX_W-1:0]  stack_rdata;
    logic [CNT_W-1:0]  top_ptr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register read back
    always_comb begin
        case (paddr[2])
            REG_BASE_ID:   prdata = {{(DATA_W-ID_W){1'b0}}, r_base_id};
            REG_POOL_SIZE: prdata = {{(DATA_W-SIZE_W){1'b0}}, r_pool_size};
            default:       prdata = '0;
        endcase
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id   <= '0;
            r_pool_size <= '0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_BASE_ID:   r_base_id   <= pwdata[ID_W-1:0];
                REG_POOL_SIZE: r_pool_size <= pwdata[SIZE_W-1:0];
                default:       r_base_id   <= r_base_id;
            endcase
        end
    end

    // usable pool size and enable
    always_comb begin
        if (32'(r_pool_size) > 32'(POOL_DEPTH)) begin
            usable = CNT_W'(POOL_DEPTH);
        end else begin
            usable = CNT_W'(r_pool_size);
        end
    end
    assign disabled = (r_base_id == '0) || (usable == '0);

    // handshakes
    assign advance    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // range check and pool index at acceptance
    assign diff = {1'b0, i_id} - {1'b0, r_base_id};
    always_comb begin
        s0_item.action   = i_action;
        s0_item.id       = i_id;
        s0_item.idx      = diff[IDX_W-1:0];
        s0_item.in_range = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(usable));
    end

    // stage register and forwarding from the step in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1          <= s0_item;
            r_use_hit     <= use_we && (use_waddr == s0_item.idx);
            r_use_hit_val <= use_wdata;
        end
        r_top_hit     <= push;
        r_top_hit_val <= r_s1.idx;
    end

    // in-use bit and stack top seen by the item in the stage
    assign use_rdata_idx_unused = r_s1.idx;
    always_comb begin
        if (r_use_hit) begin
            in_use = r_use_hit_val;
        end else begin
            in_use = use_rdata && (CNT_W'(use_rdata_idx_unused) < r_fresh_next);
        end
        top = r_top_hit ? r_top_hit_val : stack_rdata;
    end

    // one allocator step
    always_comb begin
        logic [IDX_W-1:0] slot;
        slot          = '0;
        res.ok        = 1'b0;
        res.result_id = r_s1.id;
        res.status    = ST_OK;
        cnt_dec       = 1'b0;
        fresh_inc     = 1'b0;
        push          = 1'b0;
        use_we        = 1'b0;
        use_waddr     = r_s1.idx;
        use_wdata     = 1'b0;
        if (disabled) begin
            res.status = ST_DISABLED;
            if (r_s1.action == ACT_ALLOC) begin
                res.result_id = '0;
            end
        end else if (r_s1.action == ACT_ALLOC) begin
            if (r_released_count != '0) begin
                slot    = top;
                cnt_dec = 1'b1;
            end else if (r_fresh_next < usable) begin
                slot      = r_fresh_next[IDX_W-1:0];
                fresh_inc = 1'b1;
            end
            if (cnt_dec || fresh_inc) begin
                use_we        = 1'b1;
                use_waddr     = slot;
                use_wdata     = 1'b1;
                res.ok        = 1'b1;
                res.result_id = r_base_id + ID_W'(slot);
            end else begin
                res.result_id = '0;
                res.status    = ST_EXHAUSTED;
            end
        end else if (!r_s1.in_range) begin
            res.status = ST_RANGE;
        end else if (r_s1.action == ACT_RELEASE) begin
            if (!in_use || (r_released_count == CNT_W'(POOL_DEPTH))) begin
                res.status = ST_NOT_IN_USE;
            end else begin
                use_we = 1'b1;
                push   = 1'b1;
                res.ok = 1'b1;
            end
        end else begin
            // query and the spare action code
            res.ok     = in_use;
            res.status = in_use ? ST_OK : ST_NOT_IN_USE;
        end
        if (!advance) begin
            cnt_dec   = 1'b0;
            fresh_inc = 1'b0;
            push      = 1'b0;
            use_we    = 1'b0;
        end
    end

    // counter next values, a register write clears the pool
    always_comb begin
        n_released_count = r_released_count;
        n_fresh_next     = r_fresh_next;
        if (cfg_wr) begin
            n_released_count = '0;
            n_fresh_next     = '0;
        end else begin
            if (cnt_dec) begin
                n_released_count = r_released_count - CNT_W'(1);
            end else if (push) begin
                n_released_count = r_released_count + CNT_W'(1);
            end
            if (fresh_inc) begin
                n_fresh_next = r_fresh_next + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_released_count <= '0;
            r_fresh_next     <= '0;
        end else begin
            r_released_count <= n_released_count;
            r_fresh_next     <= n_fresh_next;
        end
    end

    // stack top read follows the count the step leaves behind
    assign top_ptr = n_released_count - CNT_W'(1);

    ipa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_released_count[IDX_W-1:0]),
        .i_wdata (r_s1.idx),
        .i_re    (1'b1),
        .i_raddr (top_ptr[IDX_W-1:0]),
        .o_rdata (stack_rdata)
    );

    ipa_ram #(
        .WIDTH (1),
        .DEPTH (POOL_DEPTH)
    ) u_use_ram (
        .i_clk   (i_clk),
        .i_we    (use_we),
        .i_waddr (use_waddr),
        .i_wdata (use_wdata),
        .i_re    (accept),
        .i_raddr (s0_item.idx),
        .o_rdata (use_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ok        = r_out.ok;
    assign o_result_id = r_out.result_id;
    assign o_status    = r_out.status;

    // released IDs never outnumber issued ones
    a_count_le_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_released_count <= r_fresh_next)
        else $error("released count above fresh counter");

    // fresh counter stays inside the pool storage
    a_fresh_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh_next <= CNT_W'(POOL_DEPTH))
        else $error("fresh counter beyond pool depth");

    // ok flag agrees with the status code
    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ok == (o_status == ST_OK)))
        else $error("ok flag and status disagree");

    // a register write empties the pool
    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_released_count == '0) && (r_fresh_next == '0))
        else $error("pool not cleared by register write");

    // a release grows the stack by one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !cfg_wr) |=> (r_released_count == $past(r_released_count) + CNT_W'(1)))
        else $error("stack count not advanced on release");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    import ipa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // spare action code, answered like a query
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam int MAX_PRINTS = 40;

    typedef struct {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  id;
    } t_pool_req;

    typedef struct {
        logic             ok;
        logic [ID_W-1:0]  result_id;
        logic [ST_W-1:0]  status;
    } t_pool_ans;

    // clock, reset and block inputs
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    logic [ACT_W-1:0]  i_action    = ACT_ALLOC;
    logic [ID_W-1:0]   i_id        = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_ok;
    logic [ID_W-1:0]   o_result_id;
    logic [ST_W-1:0]   o_status;

    id_pool_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_id        (i_id),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ok        (o_ok),
        .o_result_id (o_result_id),
        .o_status    (o_status)
    );

    always #6 i_clk = ~i_clk;

    // predicted pool state
    logic [ID_W-1:0]   pool_start = '0;
    logic [SIZE_W-1:0] pool_limit = '0;
    logic [IDX_W-1:0]  rel_stack [POOL_DEPTH];
    logic [CNT_W-1:0]  rel_count = '0;
    logic [CNT_W-1:0]  fresh_idx = '0;
    logic [POOL_DEPTH-1:0] pool_busy = '0;

    // traffic bookkeeping
    t_pool_req req_queue [$];
    t_pool_ans answers_due [$];
    t_pool_req req;
    t_pool_ans want;
    logic      in_took = 1'b0;
    int        accepted_items = 0;
    int        mismatches = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        rx_tick = 0;
    int        stall_mode = 0;
    logic      rx_pat;
    logic      rx_hold = 1'b0;

    // one step of the pool: updates the predicted state, returns the answer
    function automatic t_pool_ans pool_answer(input logic [ACT_W-1:0] act,
                                              input logic [ID_W-1:0] id);
        t_pool_ans        a;
        logic [CNT_W-1:0] span;
        logic [IDX_W-1:0] slot;
        logic [31:0]      ofs;
        a.ok        = 1'b0;
        a.result_id = id;
        a.status    = ST_OK;
        span = (pool_limit > POOL_DEPTH) ? CNT_W'(POOL_DEPTH) : pool_limit;
        if (pool_start == '0 || span == '0) begin
            a.status = ST_DISABLED;
            if (act == ACT_ALLOC) a.result_id = '0;
            return a;
        end
        if (act == ACT_ALLOC) begin
            a.result_id = '0;
            if (rel_count > 0) begin
                rel_count = rel_count - 1'b1;
                slot = rel_stack[rel_count];
            end else if (fresh_idx < span) begin
                slot = fresh_idx[IDX_W-1:0];
                fresh_idx = fresh_idx + 1'b1;
            end else begin
                a.status = ST_EXHAUSTED;
                return a;
            end
            pool_busy[slot] = 1'b1;
            a.ok = 1'b1;
            a.result_id = pool_start + ID_W'(slot);
            return a;
        end
        ofs = {1'b0, id} - {1'b0, pool_start};
        if (id < pool_start || ofs >= span) begin
            a.status = ST_RANGE;
            return a;
        end
        slot = ofs[IDX_W-1:0];
        if (act == ACT_RELEASE) begin
            if (!pool_busy[slot] || rel_count >= POOL_DEPTH) begin
                a.status = ST_NOT_IN_USE;
            end else begin
                pool_busy[slot] = 1'b0;
                rel_stack[rel_count] = slot;
                rel_count = rel_count + 1'b1;
                a.ok = 1'b1;
            end
            return a;
        end
        // query and the spare code
        if (pool_busy[slot]) a.ok = 1'b1;
        else a.status = ST_NOT_IN_USE;
        return a;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp_val);
    endtask

    // monitor: result check first, then prediction for the accepted item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    flag_mismatch("result with nothing expected", 32'(o_result_id), 32'd0);
                end else begin
                    want = answers_due[0];
                    answers_due.delete(0);
                    if (o_ok !== want.ok)
                        flag_mismatch("ok", 32'(o_ok), 32'(want.ok));
                    if (o_result_id !== want.result_id)
                        flag_mismatch("result_id", 32'(o_result_id), 32'(want.result_id));
                    if (o_status !== want.status)
                        flag_mismatch("status", 32'(o_status), 32'(want.status));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                answers_due = {answers_due, pool_answer(i_action, i_id)};
                in_took = 1'b1;
                accepted_items++;
            end
        end
    end

    // driver: bursts of items with random gaps, receiver stall pattern
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            in_took = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (req_queue.size() > 0) begin
                req = req_queue[0];
                req_queue.delete(0);
                i_in_valid <= 1'b1;
                i_action   <= req.action;
                i_id       <= req.id;
                if (burst_left == 0) burst_left = $urandom_range(1, 40);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        if (rx_tick == 0) stall_mode = $urandom_range(0, 3);
        rx_tick = (rx_tick + 1) % 48;
        case (stall_mode)
            0: rx_pat = 1'b0;
            1: rx_pat = ($urandom_range(0, 3) == 0);
            2: rx_pat = ($urandom_range(0, 9) < 7);
            default: rx_pat = ((rx_tick % 5) < 2);
        endcase
        i_out_stall <= rx_hold || rx_pat;
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (accepted_items >= 300);
        rx_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    task automatic push_req(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] id);
        t_pool_req r;
        r.action = act;
        r.id     = id;
        req_queue = {req_queue, r};
    endtask

    // wait until every item went through and every result came back
    task automatic wait_drained();
        do @(posedge i_clk);
        while (req_queue.size() != 0 || answers_due.size() != 0 || i_in_valid);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, the pool is cleared in the prediction at the write edge
    task automatic cfg_write(input logic reg_sel, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        if (reg_sel == REG_BASE_ID) pool_start = data[ID_W-1:0];
        else pool_limit = data[SIZE_W-1:0];
        rel_count = '0;
        fresh_idx = '0;
        pool_busy = '0;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pool(input logic [31:0] start, input logic [10:0] size);
        logic [31:0] junk;
        junk = $urandom;
        cfg_write(REG_BASE_ID, start);
        cfg_write(REG_POOL_SIZE, {junk[31:11], size});
    endtask

    // ids mostly near the low end of the pool, where allocations land
    function automatic logic [ID_W-1:0] pick_id();
        int unsigned      r;
        int unsigned      span;
        logic [ID_W-1:0]  base;
        r    = $urandom_range(0, 99);
        span = (pool_limit > POOL_DEPTH) ? POOL_DEPTH : pool_limit;
        base = pool_start;
        if (span == 0 || r < 12) return ID_W'($urandom);
        if (r < 24) begin
            case ($urandom_range(0, 3))
                0: return base - 1'b1;
                1: return base;
                2: return base + ID_W'(span - 1);
                default: return base + ID_W'(span);
            endcase
        end
        if (r < 32) return base + ID_W'($urandom_range(0, span - 1));
        return base + ID_W'($urandom_range(0, (span < 48) ? span - 1 : 47));
    endfunction

    // windows that lean to allocate alternate with windows that lean to release
    task automatic random_items(input int n);
        int unsigned lean;
        int unsigned r;
        for (int i = 0; i < n; i++) begin
            lean = ((i % 40) < 20) ? 65 : 25;
            r = $urandom_range(0, 99);
            if (r < lean) push_req(ACT_ALLOC, ID_W'($urandom));
            else if (r < lean + (100 - lean) * 7 / 10) push_req(ACT_RELEASE, pick_id());
            else if (r < 95) push_req(ACT_QUERY, pick_id());
            else push_req(ACT_SPARE, pick_id());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // pool disabled after reset
        push_req(ACT_ALLOC, 31'h12345);
        push_req(ACT_RELEASE, 31'd5);
        push_req(ACT_QUERY, 31'h7FFF_FFFF);
        push_req(ACT_SPARE, 31'd0);
        wait_drained();

        // base set but size still zero
        cfg_write(REG_BASE_ID, 32'd100);
        push_req(ACT_ALLOC, 31'd0);
        wait_drained();

        // two-entry pool: exhaustion, range edges, release and reuse
        cfg_write(REG_POOL_SIZE, 32'd2);
        push_req(ACT_ALLOC, 31'd0);
        push_req(ACT_ALLOC, 31'd0);
        push_req(ACT_ALLOC, 31'd0);
        push_req(ACT_QUERY, 31'd101);
        push_req(ACT_QUERY, 31'd99);
        push_req(ACT_QUERY, 31'd102);
        push_req(ACT_RELEASE, 31'd100);
        push_req(ACT_RELEASE, 31'd100);
        push_req(ACT_QUERY, 31'd100);
        push_req(ACT_SPARE, 31'd101);
        push_req(ACT_ALLOC, 31'd0);
        push_req(ACT_RELEASE, 31'h7FFF_FFFF);
        wait_drained();

        // pool at the top of the id space, allocated ids wrap
        set_pool(32'hFFFF_FFFE, 11'd4);
        push_req(ACT_ALLOC, 31'd0);
        push_req(ACT_ALLOC, 31'd0);
        push_req(ACT_ALLOC, 31'd0);
        push_req(ACT_ALLOC, 31'd0);
        push_req(ACT_RELEASE, 31'd0);
        push_req(ACT_QUERY, 31'h7FFF_FFFF);
        wait_drained();

        // size back to zero disables the pool
        cfg_write(REG_POOL_SIZE, 32'd0);
        push_req(ACT_RELEASE, 31'd1);
        wait_drained();

        // random phases over a spread of settings
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_pool(32'd1, 11'd2047);
                1: set_pool({$urandom_range(0, 1) == 1, 31'h7FFF_FFFF}, 11'd1);
                2: set_pool($urandom, 11'd1024);
                3: set_pool($urandom, 11'd3);
                4: set_pool($urandom_range(1, 50), 11'($urandom_range(4, 16)));
                5: set_pool(32'h7FFF_FFF0, 11'd600);
                6: set_pool(32'd0, 11'd7);
                7: set_pool($urandom, 11'($urandom_range(0, 2047)));
                default: set_pool($urandom, 11'($urandom_range(1, 8)));
            endcase
            random_items((ph == 6) ? 40 : 125);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
